/* rtl/core/bfbs_pkg.sv */
// bfbs_pkg: shared types and constants for the bfloat16 beta scaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfbs_pkg;
   localparam logic [15:0] BETA_RESET  = 16'h3F80;
   localparam logic [15:0] DEFAULT_NAN = 16'h7FC0;
   localparam logic [15:0] QUIET_BIT   = 16'h0040;

   // special-case classification carried from stage 1 to stage 4
   typedef struct packed {
      logic        force_out;  // result fully decided by special case
      logic [15:0] force_val;
      logic        sign;
   } special_type;
endpackage
`default_nettype wire

/* rtl/core/bf16_matrix_beta_scale_top.sv */
// bf16_matrix_beta_scale_top: streaming bfloat16 scale-by-beta, four-stage pipeline.
// Depends on bfbs_pkg.
//
// Usage:
//   req_ channel carries one matrix element (c_value) plus its last marker.
//   rsp_ channel returns c_value * beta rounded to bfloat16 (scaled_value)
//   and the unchanged marker. csr_ channel writes beta (reset 1.0); write it
//   only while the pipe is empty.
// Throughput: one transaction per cycle while the output register is not stalled.
// Each request passes the stage 1, 2, 3 and 4 registers in order before rsp_valid.
// Stages: 1 classify + 8x8 mantissa multiply, 2 normalize (leading-one
//   search over 16 bits) and exponent, 3 binary32 rounding / subnormal
//   shift, 4 bfloat16 rounding and special-case merge into output register.
// Stall: the whole pipe advances only when the output register is empty or
//   being drained, so req_ready = !rsp_valid | rsp_ready. Nothing is lost or
//   repeated on back-pressure.
// Reset: synchronous; clears all valid bits and restores beta to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module bf16_matrix_beta_scale_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_c_value,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [15:0] rsp_scaled_value,
   output logic             rsp_last_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_beta_bits
);
   logic [15:0] beta_ff;
   logic        adv;
   logic [3:0]  v_ff;

   assign adv       = !v_ff[3] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= bfbs_pkg::BETA_RESET;
      end else if (csr_valid) begin
         beta_ff <= csr_beta_bits;
      end
   end

   // ---------------- stage 1: classify, multiply
   bfbs_pkg::special_type sp_in, sp1_ff, sp2_ff, sp3_ff;
   logic [15:0] prod_in, prod1_ff;
   logic signed [10:0] ex_in, ex1_ff;
   logic [15:0] c, b;
   logic c_nan, b_nan, c_snan, b_snan, c_inf, b_inf, c_zero, b_zero;
   logic [7:0] ce, be, cm, bm;
   logic [3:0] last_ff;

   always_comb begin
      c = req_c_value; b = beta_ff;
      c_nan  = (c[14:7] == 8'hFF) && (c[6:0] != 7'd0);
      b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
      c_snan = c_nan && !c[6];
      b_snan = b_nan && !b[6];
      c_inf  = c[14:0] == 15'h7F80;
      b_inf  = b[14:0] == 15'h7F80;
      c_zero = c[14:0] == 15'd0;
      b_zero = b[14:0] == 15'd0;
      sp_in.sign = c[15] ^ b[15];
      sp_in.force_out = 1'b1;
      if (b_zero)                sp_in.force_val = 16'h0000;
      else if (c_snan)           sp_in.force_val = c | bfbs_pkg::QUIET_BIT;
      else if (b_snan)           sp_in.force_val = b | bfbs_pkg::QUIET_BIT;
      else if (c_nan)            sp_in.force_val = c | bfbs_pkg::QUIET_BIT;
      else if (b_nan)            sp_in.force_val = b | bfbs_pkg::QUIET_BIT;
      else if (c_inf || b_inf)
         sp_in.force_val = c_zero ? bfbs_pkg::DEFAULT_NAN : {sp_in.sign, 15'h7F80};
      else if (c_zero)           sp_in.force_val = {sp_in.sign, 15'd0};
      else begin
         sp_in.force_out = 1'b0;
         sp_in.force_val = 16'h0000;
      end
      ce = c[14:7]; be = b[14:7];
      cm = {ce != 8'd0, c[6:0]};
      bm = {be != 8'd0, b[6:0]};
      prod_in = cm * bm;
      ex_in = 11'(ce == 8'd0 ? 9'd1 : {1'b0, ce}) + 11'(be == 8'd0 ? 9'd1 : {1'b0, be})
              - 11'sd268;
   end

   // ---------------- stage 2: normalize
   logic [3:0]  k;
   logic signed [11:0] bige_in, bige2_ff;
   logic [15:0] prod2_ff;
   logic [3:0]  k2_ff;
   always_comb begin
      k = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (prod1_ff[i]) k = 4'(i);
      end
      bige_in = 12'(ex1_ff) + 12'(k) + 12'sd127;
   end

   // ---------------- stage 3: binary32 rounding
   logic [30:0] f32_in, f32_ff;
   logic signed [11:0] s;
   logic [15:0] mant, rem, half;
   always_comb begin
      s = -(bige2_ff - 12'(k2_ff) - 12'sd127 + 12'sd149);
      mant = '0; rem = '0; half = '0;
      if (bige2_ff >= 12'sd255) begin
         f32_in = 31'h7F800000;
      end else if (bige2_ff >= 12'sd1) begin
         f32_in = {bige2_ff[7:0], 23'((32'(prod2_ff) << (5'd23 - 5'(k2_ff))))};
      end else if (s <= 12'sd0) begin
         f32_in = 31'(32'(prod2_ff) << 5'(-s));
      end else if (s >= 12'sd17) begin
         f32_in = '0;
      end else begin
         mant = prod2_ff >> s[4:0];
         rem  = prod2_ff & 16'((17'd1 << s[4:0]) - 17'd1);
         half = 16'(17'd1 << (s[4:0] - 5'd1));
         if (rem > half || (rem == half && mant[0])) mant = mant + 16'd1;
         f32_in = 31'(mant);
      end
   end

   // ---------------- stage 4: bf16 rounding and merge
   logic [31:0] rnd;
   logic [15:0] out_in, out_ff;
   always_comb begin
      rnd = {1'b0, f32_ff} + 32'h7FFF + 32'(f32_ff[16]);
      out_in = sp3_ff.force_out ? sp3_ff.force_val : {sp3_ff.sign, rnd[30:16]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp1_ff <= sp_in;   prod1_ff <= prod_in; ex1_ff <= ex_in;
         sp2_ff <= sp1_ff;  prod2_ff <= prod1_ff; bige2_ff <= bige_in; k2_ff <= k;
         sp3_ff <= sp2_ff;  f32_ff <= f32_in;
         out_ff <= out_in;
         last_ff <= {last_ff[2:0], req_last_in};
      end
   end

   assign rsp_valid        = v_ff[3];
   assign rsp_scaled_value = out_ff;
   assign rsp_last_out     = last_ff[3];
endmodule
`default_nettype wire

/* rtl/core/bfbs_checker.sv */
// bfbs_checker: port-level assertions for bf16_matrix_beta_scale_top.
// Depends on bf16_matrix_beta_scale_top (bind target).
`timescale 1ns / 1ps
`default_nettype none
module bfbs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_scaled_value,
   input wire logic        rsp_last_out
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scaled_value)
      && $stable(rsp_last_out)) else $error("rsp changed while stalled");
   a_ready_free: assert property (@(posedge clock)
      !rsp_valid |-> req_ready) else $error("req stalled with empty output");
   a_ready_stall: assert property (@(posedge clock)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("req taken during stall");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("rsp valid after reset");
endmodule

bind bf16_matrix_beta_scale_top bfbs_checker u_bfbs_checker (.*);
`default_nettype wire

/* bench/tb.sv */
// tb: self-checking bench for bf16_matrix_beta_scale_top (bfloat16 scale by beta).
// Depends on bfbs_pkg and the top level; carries its own bit-exact predictor.
`timescale 1ns / 1ps
module tb;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;      // pipe is 4 deep, plus margin
   localparam int RANDOM_ITEMS = 1950;

   typedef struct packed {
      logic [15:0] scaled;
      logic        last;
   } scaled_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_c_value = 16'h0000;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_scaled_value;
   logic        rsp_last_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_beta_bits = 16'h0000;

   scaled_elem_type pending_products[$];
   logic [15:0]  beta_now = bfbs_pkg::BETA_RESET;
   int           mismatches = 0;
   int           elems_sent = 0;
   int           elems_checked = 0;
   int           beta_writes = 0;
   int           cycle_count = 0;
   int           burst_left = 0;

   bf16_matrix_beta_scale_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_c_value(req_c_value), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_scaled_value(rsp_scaled_value), .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_beta_bits(csr_beta_bits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor: exact bf16 x bf16 product, rounded RNE to binary32,
   // then RNE to bf16. Subnormals kept, NaNs quieted.
   // ---------------------------------------------------------------
   function automatic logic is_nan_bf16(input logic [15:0] v);
      return v[14:7] == 8'hFF && v[6:0] != 7'd0;
   endfunction

   function automatic logic [15:0] beta_product(input logic [15:0] c, input logic [15:0] b);
      logic        sgn;
      logic [15:0] pick, prod;
      logic [7:0]  cm, bm;
      logic [31:0] f32, mant, rem, half;
      int          ex, k, big_e, s;
      sgn = c[15] ^ b[15];
      if (b[14:0] == 15'd0) return 16'h0000;
      if (is_nan_bf16(c) || is_nan_bf16(b)) begin
         if (is_nan_bf16(c) && !c[6]) pick = c;
         else if (is_nan_bf16(b) && !b[6]) pick = b;
         else if (is_nan_bf16(c)) pick = c;
         else pick = b;
         return pick | bfbs_pkg::QUIET_BIT;
      end
      if (c[14:0] == 15'h7F80 || b[14:0] == 15'h7F80) begin
         if (c[14:0] == 15'd0) return bfbs_pkg::DEFAULT_NAN;
         return {sgn, 15'h7F80};
      end
      if (c[14:0] == 15'd0) return {sgn, 15'd0};
      cm = {c[14:7] != 8'd0, c[6:0]};
      bm = {b[14:7] != 8'd0, b[6:0]};
      ex = (c[14:7] != 0 ? int'(c[14:7]) : 1) + (b[14:7] != 0 ? int'(b[14:7]) : 1) - 268;
      prod = cm * bm;
      k = 15;
      while (k > 0 && !prod[k]) k--;
      big_e = k + ex + 127;
      if (big_e >= 255) begin
         f32 = 32'h7F80_0000;
      end else if (big_e >= 1) begin
         f32 = (32'(big_e) << 23) | ((32'(prod) << (23 - k)) & 32'h007F_FFFF);
      end else begin
         s = -(ex + 149);
         if (s <= 0) f32 = 32'(prod) << (-s);
         else if (s >= 17) f32 = 32'd0;
         else begin
            mant = 32'(prod) >> s;
            rem  = 32'(prod) & ((32'd1 << s) - 1);
            half = 32'd1 << (s - 1);
            if (rem > half || (rem == half && mant[0])) mant++;
            f32 = mant;
         end
      end
      f32 = (f32 + 32'h7FFF + f32[16]) >> 16;
      return {sgn, f32[14:0]};
   endfunction

   // ---------------------------------------------------------------
   // Result side: stall pattern plus in-order checker.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      scaled_elem_type want;
      int           phase;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      // stall mode rotates through open, coin-flip, mostly stalled
      phase = (cycle_count / 128) % 3;
      case (phase)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_products.size() == 0) begin
            $error("unexpected transaction: scaled_value %h last_out %b",
                   rsp_scaled_value, rsp_last_out);
            mismatches++;
         end else begin
            want = pending_products.pop_front();
            elems_checked++;
            if (rsp_scaled_value !== want.scaled) begin
               $error("scaled_value expected %h actual %h", want.scaled, rsp_scaled_value);
               mismatches++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out expected %b actual %b", want.last, rsp_last_out);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side: bursts of random length separated by random gaps.
   // ---------------------------------------------------------------
   task automatic send_element(input logic [15:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid   <= 1'b1;
      req_c_value <= c;
      req_last_in <= last;
      do @(posedge clock); while (!req_ready);
      pending_products.push_back('{scaled: beta_product(c, beta_now), last: last});
      elems_sent++;
      burst_left--;
   endtask

   // beta may only change with the pipe empty
   task automatic write_beta(input logic [15:0] b);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_beta_bits <= b;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      beta_now = b;
      beta_writes++;
   endtask

   // mixes special encodings in with uniform patterns
   function automatic logic [15:0] pick_bf16();
      case ($urandom_range(0, 9))
         0: return {1'($urandom), 15'd0};
         1: return {1'($urandom), 8'h00, 7'($urandom)};
         2: return {1'($urandom), 8'hFF, 7'($urandom)};
         3: return {1'($urandom), 15'h7F80};
         4: return {1'($urandom), 8'($urandom_range(0, 8)), 7'($urandom)};
         5: return {1'($urandom), 8'($urandom_range(240, 254)), 7'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_reset_beta_specials();
      // beta still 1.0 from reset: zeros, subnormals, max, inf, NaNs
      send_element(16'h0000, 1'b0);
      send_element(16'h8000, 1'b0);
      send_element(16'h0001, 1'b0);
      send_element(16'h807F, 1'b0);
      send_element(16'h7F7F, 1'b0);
      send_element(16'hFF80, 1'b0);
      send_element(16'h7F81, 1'b0);   // signaling NaN
      send_element(16'hFFC5, 1'b1);   // quiet NaN
   endtask

   task automatic test_beta_zero();
      write_beta(16'h8000);
      send_element(16'h7F80, 1'b0);
      send_element(16'h7F81, 1'b1);
      write_beta(16'h0000);
      send_element(16'hFFFF, 1'b0);
   endtask

   task automatic test_nan_and_infinity();
      write_beta(16'hFF81);           // signaling beta
      send_element(16'h7FC1, 1'b0);   // quiet element loses to signaling beta
      send_element(16'h7F82, 1'b0);   // signaling element wins
      write_beta(16'h7FC3);
      send_element(16'h3F80, 1'b0);
      write_beta(16'hFF80);
      send_element(16'h0000, 1'b0);   // inf times zero
      send_element(16'hC000, 1'b1);
   endtask

   task automatic test_range_limits();
      write_beta(16'h7F7F);
      send_element(16'h7F7F, 1'b0);   // overflow
      send_element(16'h0001, 1'b0);
      write_beta(16'h0001);
      send_element(16'h8001, 1'b0);   // underflow to signed zero
      send_element(16'h3F80, 1'b0);
      write_beta(16'hFFFF);
      send_element(16'h1234, 1'b1);
   endtask

   task automatic test_random_stream();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) write_beta(($urandom_range(0, 2) == 0) ? pick_bf16() : 16'($urandom));
         send_element(pick_bf16(), ($urandom_range(0, 15) == 0));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_beta_specials();
      test_beta_zero();
      test_nan_and_infinity();
      test_range_limits();
      test_random_stream();

      req_valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d elements (%0d checked) across %0d beta settings",
               elems_sent, elems_checked, beta_writes);
      if (mismatches == 0 && pending_products.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/bfbs_pkg.sv
rtl/core/bf16_matrix_beta_scale_top.sv
rtl/core/bfbs_checker.sv
bench/tb.sv
